// ----- rtl/pfpp_pkg.sv -----
// ============================================================================
// pfpp_pkg - shared types and constants for the page framebuffer plotter
// Holds the store geometry, the colour and mode codes, the rotation codes
// and the structure that carries a mapped pixel between modules.
// ============================================================================
package pfpp_pkg;

  // Store geometry: 1024 bytes, each holding eight stacked pixels.
  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W      = 10;
  localparam int COORD_W     = 10;

  typedef logic [ADDR_W-1:0]         addr_t;
  typedef logic [7:0]                byte_t;
  typedef logic signed [COORD_W-1:0] coord_t;

  // Colour codes of a plot word.
  typedef enum logic [1:0] {
    COLOUR_CLEAR  = 2'd0,
    COLOUR_SET    = 2'd1,
    COLOUR_TOGGLE = 2'd2,
    COLOUR_KEEP   = 2'd3
  } colour_t;

  // Word modes.
  localparam logic MODE_PLOT = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // Rotation codes, in quarter turns.
  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  // Register indexes on the configuration port.
  localparam logic REG_ROTATION = 1'b0;

  // A pixel after clipping and rotation.
  typedef struct packed {
    logic  on_screen;
    addr_t addr;
    byte_t mask;
  } map_t;

endpackage

// ----- rtl/pfpp_map.sv -----
// ============================================================================
// pfpp_map - pixel clip, rotation and byte address mapping
// Clips signed coordinates against the rotated screen, turns them into panel
// coordinates and forms the page-order byte address and bit mask.
// ============================================================================
module pfpp_map #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic [1:0]      rotation,
  input  pfpp_pkg::coord_t pos_x,
  input  pfpp_pkg::coord_t pos_y,
  output pfpp_pkg::map_t   map
);
  import pfpp_pkg::*;

  localparam int PX_W = $clog2(SCREEN_WIDTH);
  localparam int PY_W = $clog2(SCREEN_HEIGHT);
  localparam logic [COORD_W-1:0] W_C  = COORD_W'(SCREEN_WIDTH);
  localparam logic [COORD_W-1:0] H_C  = COORD_W'(SCREEN_HEIGHT);
  localparam logic [COORD_W-1:0] W_M1 = COORD_W'(SCREEN_WIDTH - 1);
  localparam logic [COORD_W-1:0] H_M1 = COORD_W'(SCREEN_HEIGHT - 1);
  localparam addr_t W_ADDR = addr_t'(SCREEN_WIDTH);

  logic [COORD_W-1:0] ux;
  logic [COORD_W-1:0] uy;
  logic [COORD_W-1:0] vis_w;
  logic [COORD_W-1:0] vis_h;
  logic [COORD_W-1:0] px_full;
  logic [COORD_W-1:0] py_full;
  logic [PX_W-1:0]    px;
  logic [PY_W-1:0]    py;
  addr_t              page;

  assign ux = pos_x;
  assign uy = pos_y;

  // Quarter turns swap the visible width and height.
  assign vis_w = rotation[0] ? H_C : W_C;
  assign vis_h = rotation[0] ? W_C : H_C;

  always_comb begin
    case (rotation)
      ROT_90: begin
        px_full = W_M1 - uy;
        py_full = ux;
      end
      ROT_180: begin
        px_full = W_M1 - ux;
        py_full = H_M1 - uy;
      end
      ROT_270: begin
        px_full = uy;
        py_full = H_M1 - ux;
      end
      default: begin
        px_full = ux;
        py_full = uy;
      end
    endcase
  end

  assign px   = px_full[PX_W-1:0];
  assign py   = py_full[PY_W-1:0];
  assign page = addr_t'(py >> 3);

  assign map.on_screen = !pos_x[COORD_W-1] && !pos_y[COORD_W-1] &&
                         (ux < vis_w) && (uy < vis_h);
  // The address wraps modulo the store depth, so the product may be cut to ten bits.
  assign map.addr   = addr_t'(W_ADDR * page) + addr_t'(px);
  assign map.mask   = byte_t'(1) << py[2:0];

endmodule

// ----- rtl/page_framebuffer_pixel_plot_top.sv -----
// ============================================================================
// page_framebuffer_pixel_plot_top - monochrome page framebuffer with plotting
// Keeps a one-bit-per-pixel image in page order and plots or reads it back.
// ============================================================================
// The block takes one word per clock cycle and gives one result word for each.
// The coordinates are clipped, rotated and mapped to a byte address into the
// first pipeline register, the byte is then read from the 1024-byte store into
// the second, and the modified byte is written back while the result is
// loaded into the output register. A plot that hits the byte changed by the
// word just ahead of it is served from a bypass register, so back-to-back
// plots to the same byte are exact. After reset the block clears the store,
// one byte a cycle, and does not accept words during that time; rotation may
// be written throughout. The whole pipeline halts while a result waits at the
// output, so the rate is one word per cycle once the clearing pass is over and
// whenever the consumer keeps out_ready high.
module page_framebuffer_pixel_plot_top #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input words.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [9:0]  pos_x,
  input  logic [9:0]  pos_y,
  input  logic [1:0]  colour,
  input  logic [9:0]  read_address,
  // Result words.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  byte_address,
  output logic [7:0]  byte_value,
  output logic        written
);
  import pfpp_pkg::*;

  // Configuration register.
  logic [1:0] rotation;
  logic       cfg_write;

  // Clearing pass after reset.
  logic  clearing;
  addr_t clr_addr;

  // Pipeline control: every stage moves when the output register is free.
  logic adv;

  // First stage: mapped pixel.
  logic    s1_valid;
  logic    s1_mode;
  colour_t s1_colour;
  logic    s1_inside;
  addr_t   s1_addr;
  byte_t   s1_mask;
  map_t    map;

  // Second stage: read byte and bypass.
  logic    s2_valid;
  logic    s2_mode;
  colour_t s2_colour;
  logic    s2_inside;
  addr_t   s2_addr;
  byte_t   s2_mask;
  byte_t   mem_q;
  logic    byp_hit;
  byte_t   byp_data;
  byte_t   cur_byte;
  byte_t   new_byte;
  logic    pipe_we;

  // Store.
  byte_t frame_store [STORE_DEPTH];
  logic  mem_we;
  addr_t mem_waddr;
  byte_t mem_wdata;

  // --------------------------------------------------------------------------
  // Configuration port: one register, written in the access phase.
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_ROTATION);
  assign prdata    = (paddr[2] == REG_ROTATION) ? {30'b0, rotation} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation <= ROT_0;
    end else if (cfg_write) begin
      rotation <= pwdata[1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Handshake.
  // --------------------------------------------------------------------------
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv && !clearing;

  pfpp_map #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_map (
    .rotation (rotation),
    .pos_x    (coord_t'(pos_x)),
    .pos_y    (coord_t'(pos_y)),
    .map      (map)
  );

  // --------------------------------------------------------------------------
  // First stage. A read word carries its own address and never modifies.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid && in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_mode   <= mode;
      s1_colour <= colour_t'(colour);
      s1_inside <= (mode == MODE_PLOT) && map.on_screen;
      s1_addr   <= (mode == MODE_READ) ? addr_t'(read_address) : map.addr;
      s1_mask   <= map.mask;
    end
  end

  // --------------------------------------------------------------------------
  // Second stage. The store is read at the first stage's address; if the word
  // ahead writes that same byte at this edge, its new value is kept instead.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_mode   <= s1_mode;
      s2_colour <= s1_colour;
      s2_inside <= s1_inside;
      s2_addr   <= s1_addr;
      s2_mask   <= s1_mask;
      byp_hit   <= pipe_we && (s2_addr == s1_addr);
      byp_data  <= new_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mem_q <= frame_store[s1_addr];
    end
  end

  assign cur_byte = byp_hit ? byp_data : mem_q;

  always_comb begin
    case (s2_colour)
      COLOUR_CLEAR:  new_byte = cur_byte & ~s2_mask;
      COLOUR_SET:    new_byte = cur_byte | s2_mask;
      COLOUR_TOGGLE: new_byte = cur_byte ^ s2_mask;
      default:       new_byte = cur_byte;
    endcase
  end

  assign pipe_we = adv && s2_valid && (s2_mode == MODE_PLOT) && s2_inside;

  // --------------------------------------------------------------------------
  // Store write port, shared by the clearing pass and the pipeline.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + addr_t'(1);
      if (clr_addr == addr_t'(STORE_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  assign mem_we    = clearing || pipe_we;
  assign mem_waddr = clearing ? clr_addr : s2_addr;
  assign mem_wdata = clearing ? byte_t'(0) : new_byte;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_store[mem_waddr] <= mem_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // Output register. A clipped plot reports a zero address and value.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (s2_mode == MODE_READ) begin
        byte_address <= s2_addr;
        byte_value   <= cur_byte;
        written      <= 1'b0;
      end else if (s2_inside) begin
        byte_address <= s2_addr;
        byte_value   <= new_byte;
        written      <= 1'b1;
      end else begin
        byte_address <= '0;
        byte_value   <= '0;
        written      <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ready)
    else $error("word accepted during the clearing pass");

  a_no_work_while_clearing: assert property (@(posedge clk) disable iff (rst)
    (s1_valid || s2_valid) |-> !clearing)
    else $error("pipeline busy during the clearing pass");

  a_bypass_same_byte: assert property (@(posedge clk) disable iff (rst)
    (pipe_we && s1_valid && (s1_addr == s2_addr)) |=> (cur_byte == $past(new_byte)))
    else $error("word following a write to the same byte saw stale data");

endmodule
